// ----- hw/rtl/qrs_pkg.sv -----
// Shared payload types and codes for the quadratic root solver.
`default_nettype none

package qrs_pkg;

   localparam int IO_WIDTH  = 32;
   localparam int TOL_WIDTH = 16;

   localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd66;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_ONE  = 2'd1;
   localparam logic [1:0] KIND_TWO  = 2'd2;
   localparam logic [1:0] KIND_ALL  = 2'd3;

   typedef struct packed {
      logic signed [IO_WIDTH-1:0] coef_a;
      logic signed [IO_WIDTH-1:0] coef_b;
      logic signed [IO_WIDTH-1:0] coef_c;
   } req_type;

   typedef struct packed {
      logic [1:0]                 root_kind;
      logic signed [IO_WIDTH-1:0] root_one;
      logic signed [IO_WIDTH-1:0] root_two;
      logic                       saturated;
   } rsp_type;

endpackage

`default_nettype wire

// ----- hw/rtl/quadratic_root_solver.sv -----
// Pipelined solver for a*x^2 + b*x + c = 0 on signed fixed-point coefficients.
//
// req_valid/req_ready carries one coefficient set (coef_a, coef_b, coef_c) per
// transfer; rsp_valid/rsp_ready returns one result (root_kind, root_one,
// root_two, saturated) per transfer, in order. csr_wr_en/csr_wr_data write the
// zero tolerance at any edge; change it only while no item is in flight.
// One item enters per cycle while req_ready is high. An accepted item passes
// one multiply stage, one discriminant stage, DATA_WIDTH+1 square-root stages
// (one root bit per stage), one setup stage, DATA_WIDTH+1+FRAC_BITS divider
// stages (one quotient bit per stage, both roots in parallel), one saturation
// stage and a two-entry output queue.
// When the receiver stalls the queue absorbs results and the pipeline keeps
// moving until the queue is full; then req_ready drops and every stage holds.
// Reset (synchronous) empties the pipeline and queue and sets the tolerance
// to 66 (about 0.001 in Q16.16).
`default_nettype none

module quadratic_root_solver #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire qrs_pkg::req_type            req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output qrs_pkg::rsp_type                 rsp_data,
   input  wire logic                        csr_wr_en,
   input  wire logic [qrs_pkg::TOL_WIDTH-1:0] csr_wr_data
);
   import qrs_pkg::*;

   localparam int DW    = DATA_WIDTH;
   localparam int FB    = FRAC_BITS;
   localparam int TW    = TOL_WIDTH;
   localparam int SW    = DW + 1;
   localparam int RAD_W = 2 * SW;
   localparam int RW    = SW + 3;
   localparam int DWD   = 2 * DW + 2;
   localparam int CW    = (DWD > TW + FB) ? DWD : TW + FB;
   localparam int NW    = DW + 1;
   localparam int SUMW  = DW + 3;
   localparam int MW    = DW + 1;
   localparam int QW    = MW + FB;
   localparam int DRW   = MW + 1;

   localparam logic [DW-1:0] MAX_POS = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] MAX_NEG = {1'b1, {(DW-1){1'b0}}};

   typedef struct packed {
      logic [1:0] kind;
      logic       use1;
      logic       use2;
      logic       frc;
      logic       addsq;
   } ctl_type;

   typedef struct packed {
      logic [DW-1:0]   a;
      logic [DW-1:0]   b;
      logic [DW-1:0]   c;
      logic            za;
      logic            zb;
      logic            zc;
      logic [2*DW-1:0] bb;
      logic [2*DW-1:0] ac;
   } s1_type;

   typedef struct packed {
      ctl_type          ctl;
      logic [NW-1:0]    base;
      logic [NW-1:0]    den;
      logic [RAD_W-1:0] rad;
      logic [RW-1:0]    rem;
      logic [SW-1:0]    root;
   } sq_type;

   typedef struct packed {
      logic [DRW-1:0] rem;
      logic [QW-1:0]  nq;
   } half_type;

   typedef struct packed {
      ctl_type       ctl;
      logic          neg1;
      logic          neg2;
      logic [MW-1:0] dm;
      half_type      h1;
      half_type      h2;
   } dv_type;

   typedef struct packed {
      logic          sat;
      logic [DW-1:0] val;
   } rt_type;

   function automatic logic [DW-1:0] mag_dw(input logic [DW-1:0] v);
      return v[DW-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic sq_type sq_step(input sq_type s);
      sq_type         r;
      logic [RW-1:0]  rsh;
      logic [RW-1:0]  t;
      r     = s;
      rsh   = {s.rem[RW-3:0], s.rad[RAD_W-1 -: 2]};
      t     = {1'b0, s.root, 2'b01};
      r.rad = {s.rad[RAD_W-3:0], 2'b00};
      if (rsh >= t) begin
         r.rem  = rsh - t;
         r.root = {s.root[SW-2:0], 1'b1};
      end else begin
         r.rem  = rsh;
         r.root = {s.root[SW-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic half_type div_bit(input half_type h, input logic [MW-1:0] dm);
      half_type       r;
      logic [DRW-1:0] rsh;
      logic           ge;
      rsh   = {h.rem[DRW-2:0], h.nq[QW-1]};
      ge    = rsh >= {1'b0, dm};
      r.rem = ge ? (rsh - {1'b0, dm}) : rsh;
      r.nq  = {h.nq[QW-2:0], ge};
      return r;
   endfunction

   function automatic rt_type fin_root(input logic [QW-1:0] q, input logic neg,
                                       input logic en_root, input logic frc,
                                       input logic [TW-1:0] tol);
      rt_type r;
      r.sat = 1'b0;
      r.val = '0;
      if (!en_root || (frc && q <= QW'(tol))) begin
         r.val = '0;
      end else if (!neg) begin
         if (q > QW'(MAX_POS)) begin
            r.sat = 1'b1;
            r.val = MAX_POS;
         end else begin
            r.val = q[DW-1:0];
         end
      end else begin
         if (q > QW'(MAX_NEG)) begin
            r.sat = 1'b1;
            r.val = MAX_NEG;
         end else begin
            r.val = ~q[DW-1:0] + 1'b1;
         end
      end
      return r;
   endfunction

   logic [TW-1:0] tol_ff;
   logic          en;
   logic          push;
   logic          pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   // stage 1: zero tests and products
   s1_type        s1_in, s1_ff;
   logic          s1_v_ff;
   logic [DW-1:0] mb;

   always_comb begin
      s1_in.a  = req_data.coef_a[DW-1:0];
      s1_in.b  = req_data.coef_b[DW-1:0];
      s1_in.c  = req_data.coef_c[DW-1:0];
      s1_in.za = mag_dw(s1_in.a) <= DW'(tol_ff);
      s1_in.zb = mag_dw(s1_in.b) <= DW'(tol_ff);
      s1_in.zc = mag_dw(s1_in.c) <= DW'(tol_ff);
      mb       = mag_dw(s1_in.b);
      s1_in.bb = mb * mb;
      s1_in.ac = $signed(s1_in.a) * $signed(s1_in.c);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
      end
   end

   // stage 2: discriminant, case selection, divider operands
   sq_type                 sq_ff [SW+1];
   logic   [SW:0]          sq_v_ff;
   sq_type                 sq_in;
   logic signed [DWD-1:0]  d_s;
   logic                   d_neg;
   logic                   d_zero;
   logic [NW-1:0]          sa, sb, sc;

   always_comb begin
      d_s    = $signed({2'b00, s1_ff.bb}) - ($signed({{2{s1_ff.ac[2*DW-1]}}, s1_ff.ac}) <<< 2);
      d_neg  = d_s[DWD-1];
      d_zero = !d_neg && (CW'(d_s) <= (CW'(tol_ff) << FB));
      sa     = {s1_ff.a[DW-1], s1_ff.a};
      sb     = {s1_ff.b[DW-1], s1_ff.b};
      sc     = {s1_ff.c[DW-1], s1_ff.c};
      sq_in.ctl = '0;
      if (s1_ff.za) begin
         if (s1_ff.zb) begin
            sq_in.ctl.kind = s1_ff.zc ? KIND_ALL : KIND_NONE;
         end else begin
            sq_in.ctl.kind = KIND_ONE;
            sq_in.ctl.use1 = !s1_ff.zc;
         end
      end else if (d_neg) begin
         sq_in.ctl.kind = KIND_NONE;
      end else if (d_zero) begin
         sq_in.ctl.kind = KIND_ONE;
         sq_in.ctl.use1 = 1'b1;
         sq_in.ctl.use2 = 1'b1;
         sq_in.ctl.frc  = 1'b1;
      end else begin
         sq_in.ctl.kind  = KIND_TWO;
         sq_in.ctl.use1  = 1'b1;
         sq_in.ctl.use2  = 1'b1;
         sq_in.ctl.frc   = 1'b1;
         sq_in.ctl.addsq = 1'b1;
      end
      sq_in.den  = s1_ff.za ? sb : {sa[NW-2:0], 1'b0};
      sq_in.base = s1_ff.za ? (~sc + 1'b1) : (~sb + 1'b1);
      sq_in.rad  = RAD_W'(d_s);
      sq_in.rem  = '0;
      sq_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (en) begin
         sq_v_ff[0] <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff[0] <= sq_in;
      end
   end

   // square root: one root bit per stage
   for (genvar k = 0; k < SW; k++) begin : g_sq
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k+1] <= 1'b0;
         end else if (en) begin
            sq_v_ff[k+1] <= sq_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[k+1] <= sq_step(sq_ff[k]);
         end
      end
   end

   // setup: numerators (-b +/- sqrt(d), or -c when a is near zero), magnitudes and result signs
   dv_type                 dv_ff [QW+1];
   logic   [QW:0]          dv_v_ff;
   dv_type                 dv_in;
   logic signed [SUMW-1:0] sv, bx, n1, n2;
   logic [SUMW-1:0]        m1, m2;
   logic [NW-1:0]          den_s;

   always_comb begin
      den_s = sq_ff[SW].den;
      sv    = sq_ff[SW].ctl.addsq ? $signed({2'b00, sq_ff[SW].root}) : '0;
      bx    = $signed({{2{sq_ff[SW].base[NW-1]}}, sq_ff[SW].base});
      n1    = bx + sv;
      n2    = bx - sv;
      m1    = n1[SUMW-1] ? (~n1 + 1'b1) : n1;
      m2    = n2[SUMW-1] ? (~n2 + 1'b1) : n2;
      dv_in.ctl    = sq_ff[SW].ctl;
      dv_in.neg1   = n1[SUMW-1] ^ den_s[NW-1];
      dv_in.neg2   = n2[SUMW-1] ^ den_s[NW-1];
      dv_in.dm     = den_s[NW-1] ? (~den_s + 1'b1) : den_s;
      dv_in.h1.rem = '0;
      dv_in.h1.nq  = {m1[MW-1:0], {FB{1'b0}}};
      dv_in.h2.rem = '0;
      dv_in.h2.nq  = {m2[MW-1:0], {FB{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (en) begin
         dv_v_ff[0] <= sq_v_ff[SW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_ff[0] <= dv_in;
      end
   end

   // division: one quotient bit per stage for both roots
   for (genvar k = 0; k < QW; k++) begin : g_dv
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[k+1] <= 1'b0;
         end else if (en) begin
            dv_v_ff[k+1] <= dv_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_ff[k+1].ctl  <= dv_ff[k].ctl;
            dv_ff[k+1].neg1 <= dv_ff[k].neg1;
            dv_ff[k+1].neg2 <= dv_ff[k].neg2;
            dv_ff[k+1].dm   <= dv_ff[k].dm;
            dv_ff[k+1].h1   <= div_bit(dv_ff[k].h1, dv_ff[k].dm);
            dv_ff[k+1].h2   <= div_bit(dv_ff[k].h2, dv_ff[k].dm);
         end
      end
   end

   // final: near-zero forcing and saturation
   rsp_type fin_in, fin_ff;
   logic    fin_v_ff;
   rt_type  rt1, rt2;

   always_comb begin
      rt1 = fin_root(dv_ff[QW].h1.nq, dv_ff[QW].neg1, dv_ff[QW].ctl.use1,
                     dv_ff[QW].ctl.frc, tol_ff);
      rt2 = fin_root(dv_ff[QW].h2.nq, dv_ff[QW].neg2, dv_ff[QW].ctl.use2,
                     dv_ff[QW].ctl.frc, tol_ff);
      fin_in.root_kind = dv_ff[QW].ctl.kind;
      fin_in.root_one  = IO_WIDTH'($signed(rt1.val));
      fin_in.root_two  = IO_WIDTH'($signed(rt2.val));
      fin_in.saturated = rt1.sat | rt2.sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_v_ff <= 1'b0;
      end else if (en) begin
         fin_v_ff <= dv_v_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_ff <= fin_in;
      end
   end

   // output queue: two entries
   rsp_type    fifo_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign pop       = rsp_valid && rsp_ready;
   assign en        = (cnt_ff != 2'd2) || pop;
   assign push      = en && fin_v_ff;
   assign req_ready = en;
   assign rsp_valid = cnt_ff != 2'd0;
   assign rsp_data  = fifo_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wp_ff <= ~wp_ff;
         end
         if (pop) begin
            rp_ff <= ~rp_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wp_ff] <= fin_ff;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/qrs_checker.sv -----
// Port-level assertions for the quadratic root solver, bound to the top level.
`default_nettype none

module qrs_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire qrs_pkg::req_type              req_data,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire qrs_pkg::rsp_type              rsp_data
);
   import qrs_pkg::*;

   // queue comes up empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // an empty queue never blocks the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with no result waiting");

   a_none_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.root_kind == KIND_NONE || rsp_data.root_kind == KIND_ALL)
      |-> rsp_data.root_one == '0 && rsp_data.root_two == '0 && !rsp_data.saturated)
      else $error("roots or flag set on a result without roots");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // a waiting request holds until its transfer
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("waiting request changed");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_data    (req_data),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_data    (rsp_data)
);

`default_nettype wire

// ----- bench/quadratic_root_solver_tb.sv -----
// Self-checking bench for the quadratic root solver: table, random equations and back-pressure.
`timescale 1ns / 1ps
`default_nettype none

module quadratic_root_solver_tb;
   import qrs_pkg::*;

   localparam int PIPE_LAT = 87;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [TOL_WIDTH-1:0] csr_wr_data = '0;

   quadratic_root_solver dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   logic [TOL_WIDTH-1:0] tol_model;
   rsp_type roots_pending[$];
   int fail_count = 0;
   int hold_cycles = 0;
   bit stall_on = 1'b1;

   function automatic bit is_small(logic signed [127:0] v);
      logic [127:0] m;
      m = v < 0 ? -v : v;
      return m <= tol_model;
   endfunction

   function automatic logic signed [127:0] trunc_div(logic signed [127:0] num,
                                                     logic signed [127:0] den);
      logic [127:0] n, d, q;
      n = (num < 0 ? -num : num) << 16;
      d = den < 0 ? -den : den;
      if (d == 0) return 0;
      q = n / d;
      if (q > (128'd1 << 62)) q = 128'd1 << 62;
      return ((num < 0) != (den < 0)) ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic signed [31:0] clip(logic signed [127:0] v, inout logic sat);
      if (v > 128'sd2147483647) begin sat = 1'b1; return 32'h7fffffff; end
      if (v < -128'sd2147483648) begin sat = 1'b1; return 32'h80000000; end
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] root_of(logic signed [127:0] q, inout logic sat);
      if (is_small(q)) return 0;
      return clip(q, sat);
   endfunction

   function automatic rsp_type solve_quadratic(req_type e);
      rsp_type r;
      logic signed [127:0] a, b, c, d, s;
      logic [127:0] ud, rt, t;
      logic sat;
      a = e.coef_a; b = e.coef_b; c = e.coef_c;
      r = '0; sat = 1'b0;
      if (is_small(a)) begin
         if (is_small(b)) begin
            r.root_kind = is_small(c) ? KIND_ALL : KIND_NONE;
         end else begin
            r.root_kind = KIND_ONE;
            r.root_one = is_small(c) ? 32'sd0 : clip(trunc_div(-c, b), sat);
         end
      end else begin
         d = b * b - 4 * a * c;
         if (d < 0) begin
            r.root_kind = KIND_NONE;
         end else if (d <= ({112'd0, tol_model} << 16)) begin
            r.root_kind = KIND_ONE;
            r.root_one = root_of(trunc_div(-b, 2 * a), sat);
            r.root_two = r.root_one;
         end else begin
            ud = d; rt = 0;
            for (int k = 33; k >= 0; k--) begin
               t = rt | (128'd1 << k);
               if (t * t <= ud) rt = t;
            end
            s = rt;
            r.root_kind = KIND_TWO;
            r.root_one = root_of(trunc_div(-b + s, 2 * a), sat);
            r.root_two = root_of(trunc_div(-b - s, 2 * a), sat);
         end
      end
      r.saturated = sat;
      return r;
   endfunction

   // Receiver: own stall pattern plus one long hold-off.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (roots_pending.size() == 0) begin
            $error("unexpected result %p", rsp_data);
            fail_count++;
         end else begin
            want = roots_pending.pop_front();
            if (rsp_data.root_kind !== want.root_kind) begin
               $error("root_kind exp %0d got %0d", want.root_kind, rsp_data.root_kind);
               fail_count++;
            end
            if (rsp_data.root_one !== want.root_one) begin
               $error("root_one exp %0d got %0d", want.root_one, rsp_data.root_one);
               fail_count++;
            end
            if (rsp_data.root_two !== want.root_two) begin
               $error("root_two exp %0d got %0d", want.root_two, rsp_data.root_two);
               fail_count++;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $error("saturated exp %0d got %0d", want.saturated, rsp_data.saturated);
               fail_count++;
            end
         end
      end
   end

   // Offer one item and return at the falling edge after its transfer.
   task automatic send_equation(req_type e);
      req_valid <= 1'b1;
      req_data <= e;
      do @(posedge clock); while (!req_ready);
      roots_pending.push_back(solve_quadratic(e));
      @(negedge clock);
   endtask

   task automatic pause(int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (roots_pending.size() != 0) @(negedge clock);
      repeat (PIPE_LAT / 4) @(negedge clock);
   endtask

   task automatic set_tolerance(logic [TOL_WIDTH-1:0] v);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      tol_model = v;
   endtask

   function automatic logic [31:0] pick_coef();
      case ($urandom_range(0, 7))
         0: return $urandom;
         1: return $urandom_range(0, 200) - 100;
         2: return ($urandom_range(0, 1) ? 32'h80000000 : 32'h7fffffff) - $urandom_range(0, 3);
         default: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
      endcase
   endfunction

   typedef struct {
      logic [31:0] a, b, c;
      bit typed;
      rsp_type r;
   } row_type;

   row_type table_rows[] = '{
      '{32'd0, 32'd0, 32'd0, 1, '{KIND_ALL, 32'd0, 32'd0, 1'b0}},
      '{32'd0, 32'd0, 32'h00010000, 1, '{KIND_NONE, 32'd0, 32'd0, 1'b0}},
      '{32'd66, 32'hffffffbe, 32'd66, 1, '{KIND_ALL, 32'd0, 32'd0, 1'b0}},
      '{32'h00010000, 32'd0, 32'h00010000, 1, '{KIND_NONE, 32'd0, 32'd0, 1'b0}},
      '{32'd0, 32'd67, 32'h80000000, 1, '{KIND_ONE, 32'h7fffffff, 32'd0, 1'b1}},
      '{32'd0, 32'h00010000, 32'd0, 1, '{KIND_ONE, 32'd0, 32'd0, 1'b0}},
      '{32'd0, 32'h00010000, 32'h00020000, 0, '0},
      '{32'h00010000, 32'hfffe0000, 32'h00010000, 0, '0},
      '{32'h00010000, 32'hfffd0000, 32'h00020000, 0, '0},
      '{32'h00010000, 32'd0, 32'hffff0000, 0, '0},
      '{32'd67, 32'h7fffffff, 32'd0, 0, '0},
      '{32'h80000000, 32'h80000000, 32'h80000000, 0, '0},
      '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, '0},
      '{32'h7fffffff, 32'h80000000, 32'h80000000, 0, '0},
      '{32'hffffffff, 32'h00010000, 32'd0, 0, '0},
      '{32'h00010000, 32'd10, 32'd0, 0, '0},
      '{32'hffff0000, 32'h00030000, 32'hfffe0000, 0, '0}
   };

   initial begin
      req_type e;
      int burst;
      tol_model = TOL_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (table_rows[i]) begin
         e.coef_a = table_rows[i].a;
         e.coef_b = table_rows[i].b;
         e.coef_c = table_rows[i].c;
         if (table_rows[i].typed && solve_quadratic(e) !== table_rows[i].r) begin
            $error("table row %0d disagrees with predictor", i);
            fail_count++;
         end
         send_equation(e);
      end

      // Fill the pipeline while the receiver holds off.
      drain_results();
      hold_cycles = 300;
      for (int i = 0; i < 120; i++) begin
         e.coef_a = pick_coef(); e.coef_b = pick_coef(); e.coef_c = pick_coef();
         send_equation(e);
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: set_tolerance(16'd0);
            1: set_tolerance(16'hffff);
            2: set_tolerance($urandom_range(1, 2000));
            default: set_tolerance(TOL_RESET);
         endcase
         stall_on = phase != 2;
         for (int n = 0; n < 400;) begin
            burst = $urandom_range(1, 30);
            for (int k = 0; k < burst; k++) begin
               e.coef_a = pick_coef(); e.coef_b = pick_coef(); e.coef_c = pick_coef();
               if ($urandom_range(0, 9) == 0) e.coef_a = '0;
               send_equation(e);
               n++;
            end
            if (phase != 2) pause($urandom_range(0, 8));
         end
      end

      drain_results();
      repeat (PIPE_LAT) @(negedge clock);
      if (fail_count == 0 && roots_pending.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/qrs_pkg.sv
hw/rtl/quadratic_root_solver.sv
hw/rtl/qrs_checker.sv
bench/quadratic_root_solver_tb.sv
